// ===== rtl/prl_pkg.sv =====
package prl_pkg;

  // Port widths fixed by the command and result formats.
  localparam int unsigned PORT_KEY_W = 64;
  localparam int unsigned PORT_POS_W = 7;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned STATUS_W   = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT    = 2'd0,
    MODE_REMOVE    = 2'd1,
    MODE_FIND_NAME = 2'd2,
    MODE_FIND_ID   = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  // What every cell of the chain does in one cycle.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_e;

endpackage

// ===== rtl/positional_record_list_unit.sv =====
// Ordered list of up to CAPACITY records (id key, name key), held in a chain
// of cells, one record per cell. Insert (mode 0) opens a slot at a 0-based
// position and remove (mode 1) closes one; each cell above the position, and
// on remove the one at it, takes its neighbor's record in the same cycle,
// and the result goes into the output register along with the chain. Find by
// name (mode 2) and find by id (mode 3) rotate the whole chain once, comparing
// the key against the record passing cell 0, then post the result from a
// finish state that waits until the output register is free. One command
// is in work at a time; a result waits in the output register, and the next
// command is taken only once it is empty or draining. Keys are cut to
// their low KEY_BITS bits; found keys come back zero-extended. A position
// beyond the list or a search miss gives status 1, an insert into a full list
// gives status 2, and entry_count is the record count after the command.
module positional_record_list_unit #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned KEY_BITS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [prl_pkg::MODE_W-1:0]          mode_i,
  input  logic [prl_pkg::PORT_POS_W-1:0]      position_i,
  input  logic [prl_pkg::PORT_KEY_W-1:0]      id_key_i,
  input  logic [prl_pkg::PORT_KEY_W-1:0]      name_key_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [prl_pkg::STATUS_W-1:0]        status_o,
  output logic [prl_pkg::PORT_POS_W-1:0]      found_position_o,
  output logic [prl_pkg::PORT_KEY_W-1:0]      found_id_o,
  output logic [prl_pkg::PORT_KEY_W-1:0]      found_name_o,
  output logic [prl_pkg::PORT_POS_W-1:0]      entry_count_o
);

  localparam int unsigned REC_W = 2 * KEY_BITS;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CMP_W = (CNT_W > prl_pkg::PORT_POS_W) ? CNT_W : prl_pkg::PORT_POS_W;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_STEP  = IDX_W'(CAPACITY - 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  // Control state.
  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] step_q, step_d;
  logic             hit_q, hit_d;
  logic             out_valid_q, out_valid_d;

  // Search payload.
  prl_pkg::mode_e      smode_q, smode_d;
  logic [KEY_BITS-1:0] skey_q, skey_d;
  logic [CNT_W-1:0]    hit_pos_q, hit_pos_d;
  logic [REC_W-1:0]    hit_rec_q, hit_rec_d;

  // Output register payload.
  prl_pkg::status_e             status_q, status_d;
  logic [prl_pkg::PORT_POS_W-1:0] fpos_q, fpos_d;
  logic [prl_pkg::PORT_KEY_W-1:0] fid_q, fid_d;
  logic [prl_pkg::PORT_KEY_W-1:0] fname_q, fname_d;
  logic [prl_pkg::PORT_POS_W-1:0] fcount_q, fcount_d;

  // Chain signals.
  prl_pkg::cell_op_e cell_op;
  logic [CNT_W-1:0]  cell_pos;
  logic [REC_W-1:0]  new_rec;
  logic [REC_W-1:0]  rec [CAPACITY];

  logic           can_load;
  logic           in_fire;
  prl_pkg::mode_e in_mode;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic [KEY_BITS-1:0] head_id;
  logic [KEY_BITS-1:0] head_name;
  logic              head_match;

  assign in_mode   = prl_pkg::mode_e'(mode_i);
  assign pos_ext   = CMP_W'(position_i);
  assign cnt_ext   = CMP_W'(count_q);
  assign new_rec   = {id_key_i[KEY_BITS-1:0], name_key_i[KEY_BITS-1:0]};
  // Position is only used by the cells once checked against the count,
  // so it fits the count width.
  assign cell_pos  = CNT_W'(position_i);

  assign head_id   = rec[0][REC_W-1:KEY_BITS];
  assign head_name = rec[0][KEY_BITS-1:0];
  assign head_match = (smode_q == prl_pkg::MODE_FIND_NAME) ? (head_name == skey_q)
                                                            : (head_id == skey_q);

  // Output register frees up when empty or being drained this cycle.
  assign can_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !can_load;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    step_d      = step_q;
    hit_d       = hit_q;
    smode_d     = smode_q;
    skey_d      = skey_q;
    hit_pos_d   = hit_pos_q;
    hit_rec_d   = hit_rec_q;
    status_d    = status_q;
    fpos_d      = fpos_q;
    fid_d       = fid_q;
    fname_d     = fname_q;
    fcount_d    = fcount_q;
    cell_op     = prl_pkg::CELL_HOLD;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_mode)
            prl_pkg::MODE_INSERT: begin
              // Position check comes before the full check.
              if (pos_ext > cnt_ext) begin
                status_d = prl_pkg::STATUS_MISS;
              end else if (count_q == FULL_COUNT) begin
                status_d = prl_pkg::STATUS_FULL;
              end else begin
                status_d = prl_pkg::STATUS_OK;
                cell_op  = prl_pkg::CELL_INSERT;
                count_d  = count_q + CNT_W'(1);
              end
              fpos_d      = '0;
              fid_d       = '0;
              fname_d     = '0;
              fcount_d    = prl_pkg::PORT_POS_W'(count_d);
              out_valid_d = 1'b1;
            end
            prl_pkg::MODE_REMOVE: begin
              if (pos_ext >= cnt_ext) begin
                status_d = prl_pkg::STATUS_MISS;
              end else begin
                status_d = prl_pkg::STATUS_OK;
                cell_op  = prl_pkg::CELL_REMOVE;
                count_d  = count_q - CNT_W'(1);
              end
              fpos_d      = '0;
              fid_d       = '0;
              fname_d     = '0;
              fcount_d    = prl_pkg::PORT_POS_W'(count_d);
              out_valid_d = 1'b1;
            end
            default: begin
              // Latch the key and start one full turn of the chain.
              smode_d = in_mode;
              skey_d  = (in_mode == prl_pkg::MODE_FIND_NAME) ? name_key_i[KEY_BITS-1:0]
                                                             : id_key_i[KEY_BITS-1:0];
              step_d  = '0;
              hit_d   = 1'b0;
              state_d = ST_SEARCH;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        // Cell 0 now holds the record that sat at position step.
        cell_op = prl_pkg::CELL_ROTATE;
        if (!hit_q && (CNT_W'(step_q) < count_q) && head_match) begin
          hit_d     = 1'b1;
          hit_pos_d = CNT_W'(step_q) + CNT_W'(1);
          hit_rec_d = rec[0];
        end
        step_d = step_q + IDX_W'(1);
        if (step_q == LAST_STEP) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (can_load) begin
          status_d    = hit_q ? prl_pkg::STATUS_OK : prl_pkg::STATUS_MISS;
          fpos_d      = hit_q ? prl_pkg::PORT_POS_W'(hit_pos_q) : '0;
          fid_d       = hit_q ? prl_pkg::PORT_KEY_W'(hit_rec_q[REC_W-1:KEY_BITS]) : '0;
          fname_d     = hit_q ? prl_pkg::PORT_KEY_W'(hit_rec_q[KEY_BITS-1:0]) : '0;
          fcount_d    = prl_pkg::PORT_POS_W'(count_q);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Chain of record cells; the last cell wraps to cell 0 for rotation.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    prl_cell #(
      .REC_W (REC_W),
      .POS_W (CNT_W),
      .IDX   (g)
    ) u_cell (
      .clk_i       (clk_i),
      .op_i        (cell_op),
      .pos_i       (cell_pos),
      .new_rec_i   (new_rec),
      .left_rec_i  (rec[(g == 0) ? 0 : g - 1]),
      .right_rec_i (rec[(g == CAPACITY - 1) ? 0 : g + 1]),
      .rec_o       (rec[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      step_q      <= step_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smode_q   <= smode_d;
    skey_q    <= skey_d;
    hit_pos_q <= hit_pos_d;
    hit_rec_q <= hit_rec_d;
    status_q  <= status_d;
    fpos_q    <= fpos_d;
    fid_q     <= fid_d;
    fname_q   <= fname_d;
    fcount_q  <= fcount_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign found_position_o = fpos_q;
  assign found_id_o       = fid_q;
  assign found_name_o     = fname_q;
  assign entry_count_o    = fcount_q;

endmodule

// ===== rtl/prl_cell.sv =====
module prl_cell #(
  parameter int unsigned REC_W = 128,
  parameter int unsigned POS_W = 7,
  parameter int unsigned IDX   = 0
) (
  input  logic                clk_i,
  input  prl_pkg::cell_op_e   op_i,
  input  logic [POS_W-1:0]    pos_i,
  input  logic [REC_W-1:0]    new_rec_i,
  input  logic [REC_W-1:0]    left_rec_i,
  input  logic [REC_W-1:0]    right_rec_i,
  output logic [REC_W-1:0]    rec_o
);

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

  logic [REC_W-1:0] rec_q, rec_d;

  always_comb begin
    rec_d = rec_q;
    unique case (op_i)
      prl_pkg::CELL_INSERT: begin
        // Cells above the slot move up, the slot takes the new record.
        if (MY_IDX > pos_i) begin
          rec_d = left_rec_i;
        end else if (MY_IDX == pos_i) begin
          rec_d = new_rec_i;
        end
      end
      prl_pkg::CELL_REMOVE: begin
        if (MY_IDX >= pos_i) begin
          rec_d = right_rec_i;
        end
      end
      prl_pkg::CELL_ROTATE: rec_d = right_rec_i;
      default:              rec_d = rec_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

// ===== bench/positional_record_list_unit_test.sv =====
`timescale 1ns / 100ps

module positional_record_list_unit_test;

  localparam int unsigned LIST_CAP   = 64;
  localparam int unsigned POS_W      = prl_pkg::PORT_POS_W;
  localparam int unsigned KEY_W      = prl_pkg::PORT_KEY_W;
  localparam int unsigned ITEM_COUNT = 1000;
  localparam int unsigned CYCLE_CAP  = 1000000;
  // A search walks the whole chain once and then posts its result.
  localparam int unsigned DRAIN_WAIT = LIST_CAP + 8;

  // One expected result transfer.
  typedef struct {
    prl_pkg::status_e status;
    logic [POS_W-1:0] found_pos;
    logic [KEY_W-1:0] found_id;
    logic [KEY_W-1:0] found_name;
    logic [POS_W-1:0] entry_count;
  } list_result_t;

  // Shadow copy of the record list. Every accepted command updates it and queues
  // the result the block owes for that command.
  class record_list_tracker;
    logic [KEY_W-1:0] id_rec   [LIST_CAP];
    logic [KEY_W-1:0] name_rec [LIST_CAP];
    int unsigned      count;
    int unsigned      errors;
    list_result_t     expected_q [$];

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_command(prl_pkg::mode_e mode, logic [POS_W-1:0] pos,
                               logic [KEY_W-1:0] idk, logic [KEY_W-1:0] namek);
      list_result_t r;
      int unsigned  p;
      int unsigned  k;
      int unsigned  hit;
      p             = pos;
      hit           = 0;
      r.status      = prl_pkg::STATUS_OK;
      r.found_pos   = '0;
      r.found_id    = '0;
      r.found_name  = '0;
      case (mode)
        prl_pkg::MODE_INSERT: begin
          // Check the position before the capacity.
          if (p > count) begin
            r.status = prl_pkg::STATUS_MISS;
          end else if (count >= LIST_CAP) begin
            r.status = prl_pkg::STATUS_FULL;
          end else begin
            for (k = count; k > p; k--) begin
              id_rec[k]   = id_rec[k-1];
              name_rec[k] = name_rec[k-1];
            end
            id_rec[p]   = idk;
            name_rec[p] = namek;
            count++;
          end
        end
        prl_pkg::MODE_REMOVE: begin
          if (p >= count) begin
            r.status = prl_pkg::STATUS_MISS;
          end else begin
            for (k = p; k + 1 < count; k++) begin
              id_rec[k]   = id_rec[k+1];
              name_rec[k] = name_rec[k+1];
            end
            count--;
          end
        end
        default: begin
          // Report the first match only.
          for (k = 0; k < count && hit == 0; k++) begin
            if (mode == prl_pkg::MODE_FIND_NAME ? name_rec[k] == namek
                                                : id_rec[k] == idk) begin
              hit = k + 1;
            end
          end
          if (hit == 0) begin
            r.status = prl_pkg::STATUS_MISS;
          end else begin
            r.found_pos  = hit[POS_W-1:0];
            r.found_id   = id_rec[hit-1];
            r.found_name = name_rec[hit-1];
          end
        end
      endcase
      r.entry_count = count[POS_W-1:0];
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [prl_pkg::STATUS_W-1:0] st, logic [POS_W-1:0] fpos,
                               logic [KEY_W-1:0] fid, logic [KEY_W-1:0] fname,
                               logic [POS_W-1:0] ecount);
      list_result_t want;
      if (expected_q.size() == 0) begin
        $error("result transfer with no command outstanding");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (st !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, st);
        errors++;
      end
      if (fpos !== want.found_pos) begin
        $error("found_position: expected %0d, actual %0d", want.found_pos, fpos);
        errors++;
      end
      if (fid !== want.found_id) begin
        $error("found_id: expected %h, actual %h", want.found_id, fid);
        errors++;
      end
      if (fname !== want.found_name) begin
        $error("found_name: expected %h, actual %h", want.found_name, fname);
        errors++;
      end
      if (ecount !== want.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", want.entry_count, ecount);
        errors++;
      end
    endfunction
  endclass

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_stall_o;
  logic [prl_pkg::MODE_W-1:0]   mode_i      = prl_pkg::MODE_INSERT;
  logic [POS_W-1:0]             position_i  = '0;
  logic [KEY_W-1:0]             id_key_i    = '0;
  logic [KEY_W-1:0]             name_key_i  = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [prl_pkg::STATUS_W-1:0] status_o;
  logic [POS_W-1:0]             found_position_o;
  logic [KEY_W-1:0]             found_id_o;
  logic [KEY_W-1:0]             found_name_o;
  logic [POS_W-1:0]             entry_count_o;

  record_list_tracker tracker = new();

  // Sender knobs: a calm stretch has no gaps; a hold-off request makes the
  // receiver stall for a long, counted stretch.
  bit          sender_calm   = 1'b0;
  bit          hold_off_req  = 1'b0;
  int unsigned cycle_count   = 0;

  positional_record_list_unit #(
    .CAPACITY(LIST_CAP),
    .KEY_BITS(KEY_W)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .position_i      (position_i),
    .id_key_i        (id_key_i),
    .name_key_i      (name_key_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .found_position_o(found_position_o),
    .found_id_o      (found_id_o),
    .found_name_o    (found_name_o),
    .entry_count_o   (entry_count_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Stop a hung run; the cap is several times the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("positional_record_list_unit_test failed");
      $finish;
    end
  end

  // Check every result transfer against the oldest expectation. All block
  // inputs change by nonblocking assignment, so these are pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_result(status_o, found_position_o, found_id_o, found_name_o,
                           entry_count_o);
    end
  end

  // Receiver: mix short stalls, a few long ones and quiet stretches; honor a
  // hold-off request with one long stall counted here.
  initial begin
    int unsigned r;
    int unsigned len;
    bit          stall;
    forever begin
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          stall = 1'b0;
          len   = $urandom_range(50, 200);
        end else begin
          stall = 1'($urandom_range(0, 1));
          len   = (r < 95) ? $urandom_range(1, 3) : $urandom_range(15, 40);
        end
        out_stall_i <= stall;
        repeat (len) @(posedge clk_i);
      end
    end
  end

  // Hold the command until the block takes it, then record the transfer.
  task automatic issue_command(prl_pkg::mode_e mode, logic [POS_W-1:0] pos,
                               logic [KEY_W-1:0] idk, logic [KEY_W-1:0] namek);
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    position_i <= pos;
    id_key_i   <= idk;
    name_key_i <= namek;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_command(mode, pos, idk, namek);
    sender_gap();
  endtask

  // Mostly back to back, sometimes a short gap, rarely a long pause. Drop
  // valid only when a gap really follows.
  task automatic sender_gap();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (sender_calm || r < 65) begin
      n = 0;
    end else if (r < 94) begin
      n = $urandom_range(1, 3);
    end else begin
      n = $urandom_range(10, 40);
    end
    if (n != 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Wide random keys, a small pool for duplicates, and the edge patterns.
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      return {$urandom, $urandom};
    end else if (r < 8) begin
      return KEY_W'($urandom_range(0, 7));
    end else if (r == 8) begin
      return '1;
    end
    return KEY_W'(1) << $urandom_range(0, KEY_W - 1);
  endfunction

  initial begin
    int unsigned      i;
    int unsigned      r;
    int unsigned      cnt;
    bit               filling;
    prl_pkg::mode_e   mode;
    logic [POS_W-1:0] pos;
    logic [KEY_W-1:0] idk;
    logic [KEY_W-1:0] namek;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty list: searches miss, removes and inserts past the end are refused.
    issue_command(prl_pkg::MODE_FIND_NAME, 7'd0, '1, '0);
    issue_command(prl_pkg::MODE_FIND_ID, 7'd0, '1, '0);
    issue_command(prl_pkg::MODE_REMOVE, 7'd0, '0, '0);
    issue_command(prl_pkg::MODE_INSERT, 7'd1, '1, '1);
    issue_command(prl_pkg::MODE_INSERT, 7'd127, '1, '1);
    // Build a short list at the front, the end and the middle.
    issue_command(prl_pkg::MODE_INSERT, 7'd0, '1, '0);
    issue_command(prl_pkg::MODE_INSERT, 7'd1, '0, '1);
    issue_command(prl_pkg::MODE_INSERT, 7'd1, 64'hAAAA_AAAA_AAAA_AAAA,
                  64'h5555_5555_5555_5555);
    issue_command(prl_pkg::MODE_INSERT, 7'd0, 64'h5555_5555_5555_5555,
                  64'hAAAA_AAAA_AAAA_AAAA);
    issue_command(prl_pkg::MODE_INSERT, 7'd4, 64'd1, '1);
    // Duplicate name: the first match wins. Hit first, middle and last.
    issue_command(prl_pkg::MODE_FIND_NAME, 7'd0, '0, '1);
    issue_command(prl_pkg::MODE_FIND_ID, 7'd0, '0, '0);
    issue_command(prl_pkg::MODE_FIND_ID, 7'd0, 64'd1, '0);
    issue_command(prl_pkg::MODE_FIND_NAME, 7'd0, '0, 64'hAAAA_AAAA_AAAA_AAAA);
    issue_command(prl_pkg::MODE_FIND_NAME, 7'd0, '0, 64'h1234);
    // Remove out of range, then last, first and middle.
    issue_command(prl_pkg::MODE_REMOVE, 7'd5, '0, '0);
    issue_command(prl_pkg::MODE_REMOVE, 7'd127, '0, '0);
    issue_command(prl_pkg::MODE_REMOVE, 7'd4, '0, '0);
    issue_command(prl_pkg::MODE_REMOVE, 7'd0, '0, '0);
    issue_command(prl_pkg::MODE_REMOVE, 7'd1, '0, '0);
    issue_command(prl_pkg::MODE_FIND_ID, 7'd0, '1, '0);
    issue_command(prl_pkg::MODE_REMOVE, 7'd0, '0, '0);
    issue_command(prl_pkg::MODE_REMOVE, 7'd0, '0, '0);
    issue_command(prl_pkg::MODE_REMOVE, 7'd0, '0, '0);

    // Random part: alternate fill and drain phases so the list runs between
    // empty and full, with searches mostly for keys that are present.
    filling = 1'b0;
    for (i = 0; i < ITEM_COUNT; i++) begin
      if (i % 160 == 0) begin
        filling = !filling;
      end
      if (i % 40 == 0) begin
        sender_calm = ($urandom_range(0, 3) == 0);
      end
      if (i == 300) begin
        hold_off_req = 1'b1;
      end
      if (i == 600) begin
        // Pause the sender until every outstanding result is back.
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (tracker.pending() != 0);
      end

      cnt = tracker.count;
      r   = $urandom_range(0, 99);
      if (filling) begin
        mode = (r < 65) ? prl_pkg::MODE_INSERT : (r < 75) ? prl_pkg::MODE_REMOVE :
               (r < 88) ? prl_pkg::MODE_FIND_NAME : prl_pkg::MODE_FIND_ID;
      end else begin
        mode = (r < 15) ? prl_pkg::MODE_INSERT : (r < 70) ? prl_pkg::MODE_REMOVE :
               (r < 85) ? prl_pkg::MODE_FIND_NAME : prl_pkg::MODE_FIND_ID;
      end

      // Mostly legal positions; some noise over the whole field.
      if (mode == prl_pkg::MODE_FIND_NAME || mode == prl_pkg::MODE_FIND_ID ||
          $urandom_range(0, 99) < 12) begin
        pos = POS_W'($urandom_range(0, 127));
      end else if (mode == prl_pkg::MODE_INSERT) begin
        pos = POS_W'($urandom_range(0, cnt));
      end else begin
        pos = (cnt != 0) ? POS_W'($urandom_range(0, cnt - 1)) : '0;
      end

      idk   = pick_key();
      namek = pick_key();
      if (cnt != 0 && $urandom_range(0, 99) < 75) begin
        if (mode == prl_pkg::MODE_FIND_NAME) begin
          namek = tracker.name_rec[$urandom_range(0, cnt - 1)];
        end else if (mode == prl_pkg::MODE_FIND_ID) begin
          idk = tracker.id_rec[$urandom_range(0, cnt - 1)];
        end
      end

      issue_command(mode, pos, idk, namek);
    end

    // Drain, then give a late or extra result time to show up.
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("positional_record_list_unit_test passed");
    end else begin
      $display("positional_record_list_unit_test failed");
    end
    $finish;
  end

endmodule
